>>> hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, cond) \
  `ASSERT_CLK(lbl, !(cond))

`endif

>>> hdl/mccp_pkg.sv
// Types and constants of the minimum-cost column path block.
package mccp_pkg;

  localparam int SumWidth = 22;
  localparam logic [SumWidth-1:0] SumMax = 22'h3FFFFF;

  typedef enum logic [1:0] {
    STEP_UP   = 2'd0,
    STEP_SAME = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  localparam int CountWidth = 7;

endpackage

>>> hdl/mccp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mccp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/min_cost_column_path_top.sv
// Minimum-cost column path: grid loading, min search, traceback and path output.
//
// Usage: write row_count (address 0) and column_count (address 4) over the APB
// port while the block is idle; a write restarts the grid. Feed grid cells with
// start while busy is low, column by column, top row first; one cell per
// transfer. Each cell passes through the shared add/compare unit in the states
// S_A_MID (top row only), S_A_DN and S_CALC, as the cost memory has a single
// read port. After the last cell the block finds the least final total, scans
// the final column, traces each minimal row back and compares it with the best
// path so far. It then emits one result per column on path_row/total_cost/
// last_item, with result_strobe high for one cycle; last_item marks the final
// column. The receiver cannot stall.
// busy stays high from a cell transfer until that cell is stored, and through
// the whole end phase until the last result is out.
// Reset (synchronous, active high) sets both counts to 1, clears the grid
// position and leaves the block idle. Memories need no clearing pass.
module min_cost_column_path_top #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLUMNS = 64,
  parameter int COST_WIDTH  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] cell_cost,
  output logic        result_strobe,
  output logic [6:0]  path_row,
  output logic [21:0] total_cost,
  output logic        last_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "assert_macros.svh"

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int RA = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int PathDepth = (MAX_COLUMNS < 2) ? 2 : MAX_COLUMNS;
  localparam int CA = $clog2(PathDepth);
  localparam int PredDepth = MAX_ROWS * MAX_COLUMNS;
  localparam int PA = $clog2(PredDepth);
  localparam int SW = mccp_pkg::SumWidth;
  localparam int CostBits = (COST_WIDTH < 16) ? COST_WIDTH : 16;
  localparam logic [15:0] CostMask = 16'((32'd1 << CostBits) - 32'd1);

  typedef enum logic [3:0] {
    S_IDLE, S_A_MID, S_A_DN, S_CALC, S_MIN, S_SCAN, S_SCANW,
    S_TR, S_TRW, S_CMP, S_CMPW, S_OUT_RD, S_OUT_CAP
  } state_t;

  state_t state;

  logic [mccp_pkg::CountWidth-1:0] row_count;
  logic [mccp_pkg::CountWidth-1:0] column_count;
  logic [RW-1:0] rows;
  logic [CW-1:0] cols;
  logic [31:0]   rows_w;
  logic [31:0]   cols_w;

  logic [RW-1:0] r;
  logic [CW-1:0] col;
  logic [RW-1:0] idx;
  logic [RW-1:0] x;
  logic [CW-1:0] tc;
  logic [15:0]   cost_q;
  logic [SW-1:0] up;
  logic [SW-1:0] mid;
  logic [SW-1:0] total;
  logic          best_sel;
  logic          best_valid;

  logic [RA-1:0] cost_raddr;
  logic [SW-1:0] cost_rd0;
  logic [SW-1:0] cost_rd1;
  logic [SW-1:0] cost_rd;
  logic [SW-1:0] prev_rd;
  logic          cost_we;
  logic [SW-1:0] best_c;
  logic [1:0]    step_c;
  logic [SW:0]   sum_ext;
  logic [SW-1:0] sum_sat;

  logic [PA-1:0] pred_waddr;
  logic [PA-1:0] pred_raddr;
  logic [1:0]    pred_rd;

  logic [CA-1:0] path_addr;
  logic          path_we;
  logic [RA-1:0] path_rd0;
  logic [RA-1:0] path_rd1;
  logic [RA-1:0] cand_rd;
  logic [RA-1:0] best_rd;

  logic          cfg_wr;
  logic [RW-1:0] idx_next;

  assign rows_w = (row_count == '0) ? 32'd1 :
                  ((32'(row_count) > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : 32'(row_count));
  assign cols_w = (column_count == '0) ? 32'd1 :
                  ((32'(column_count) > 32'(MAX_COLUMNS)) ? 32'(MAX_COLUMNS)
                                                          : 32'(column_count));
  assign rows = RW'(rows_w);
  assign cols = CW'(cols_w);

  assign busy   = (state != S_IDLE);
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = paddr[2] ? 32'(column_count) : 32'(row_count);

  assign cost_rd = col[0] ? cost_rd0 : cost_rd1;
  assign prev_rd = (col == '0) ? '0 : cost_rd;
  assign cand_rd = best_sel ? path_rd0 : path_rd1;
  assign best_rd = best_sel ? path_rd1 : path_rd0;
  assign idx_next = idx + RW'(1);

  always_comb begin
    best_c = mid;
    step_c = mccp_pkg::STEP_SAME;
    if (r != '0 && up <= best_c) begin
      best_c = up;
      step_c = mccp_pkg::STEP_UP;
    end
    if ((RW+1)'(r) + (RW+1)'(1) < (RW+1)'(rows) && prev_rd < best_c) begin
      best_c = prev_rd;
      step_c = mccp_pkg::STEP_DOWN;
    end
    sum_ext = {1'b0, best_c} + (SW+1)'(cost_q);
    sum_sat = sum_ext[SW] ? mccp_pkg::SumMax : sum_ext[SW-1:0];
  end

  always_comb begin
    case (state)
      S_A_MID:        cost_raddr = RA'(r);
      S_A_DN:         cost_raddr = RA'(r + RW'(1));
      S_MIN, S_SCAN:  cost_raddr = RA'(idx);
      default:        cost_raddr = RA'(r);
    endcase
    cost_we    = (state == S_CALC);
    pred_waddr = PA'(col) * PA'(MAX_ROWS) + PA'(r);
    pred_raddr = PA'(tc) * PA'(MAX_ROWS) + PA'(x);
    path_addr  = CA'(tc);
    path_we    = (state == S_TR);
  end

  mccp_ram #(.WIDTH(SW), .DEPTH(MAX_ROWS)) u_cost0 (
    .clk(clk), .we(cost_we & ~col[0]), .waddr(RA'(r)), .wdata(sum_sat),
    .raddr(cost_raddr), .rdata(cost_rd0)
  );

  mccp_ram #(.WIDTH(SW), .DEPTH(MAX_ROWS)) u_cost1 (
    .clk(clk), .we(cost_we & col[0]), .waddr(RA'(r)), .wdata(sum_sat),
    .raddr(cost_raddr), .rdata(cost_rd1)
  );

  mccp_ram #(.WIDTH(2), .DEPTH(PredDepth)) u_pred (
    .clk(clk), .we(cost_we), .waddr(pred_waddr), .wdata(step_c),
    .raddr(pred_raddr), .rdata(pred_rd)
  );

  mccp_ram #(.WIDTH(RA), .DEPTH(PathDepth)) u_path0 (
    .clk(clk), .we(path_we & best_sel), .waddr(path_addr), .wdata(RA'(x)),
    .raddr(path_addr), .rdata(path_rd0)
  );

  mccp_ram #(.WIDTH(RA), .DEPTH(PathDepth)) u_path1 (
    .clk(clk), .we(path_we & ~best_sel), .waddr(path_addr), .wdata(RA'(x)),
    .raddr(path_addr), .rdata(path_rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      row_count     <= 7'd1;
      column_count  <= 7'd1;
      r             <= '0;
      col           <= '0;
      idx           <= '0;
      tc            <= '0;
      best_sel      <= 1'b0;
      best_valid    <= 1'b0;
      result_strobe <= 1'b0;
      last_item     <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      last_item     <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cost_q <= cell_cost & CostMask;
            state  <= (r == '0) ? S_A_MID : S_A_DN;
          end
        end
        S_A_MID: begin
          state <= S_A_DN;
        end
        S_A_DN: begin
          if (r == '0) begin
            mid <= prev_rd;
          end
          state <= S_CALC;
        end
        S_CALC: begin
          up  <= mid;
          mid <= prev_rd;
          if (r + RW'(1) == rows) begin
            r   <= '0;
            col <= col + CW'(1);
            if (col + CW'(1) == cols) begin
              idx   <= '0;
              state <= S_MIN;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            r     <= r + RW'(1);
            state <= S_IDLE;
          end
        end
        S_MIN: begin
          if (idx != '0 && (idx == RW'(1) || cost_rd < total)) begin
            total <= cost_rd;
          end
          if (idx == rows) begin
            idx        <= '0;
            best_valid <= 1'b0;
            state      <= S_SCAN;
          end else begin
            idx <= idx_next;
          end
        end
        S_SCAN: begin
          state <= S_SCANW;
        end
        S_SCANW: begin
          if (cost_rd == total) begin
            x     <= idx;
            tc    <= cols - CW'(1);
            state <= S_TR;
          end else if (idx_next == rows) begin
            tc    <= '0;
            state <= S_OUT_RD;
          end else begin
            idx   <= idx_next;
            state <= S_SCAN;
          end
        end
        S_TR: begin
          state <= S_TRW;
        end
        S_TRW: begin
          if (pred_rd == mccp_pkg::STEP_UP && x != '0) begin
            x <= x - RW'(1);
          end else if (pred_rd == mccp_pkg::STEP_DOWN && x + RW'(1) < rows) begin
            x <= x + RW'(1);
          end
          if (tc == '0) begin
            if (!best_valid) begin
              best_sel   <= ~best_sel;
              best_valid <= 1'b1;
              if (idx_next == rows) begin
                state <= S_OUT_RD;
              end else begin
                idx   <= idx_next;
                state <= S_SCAN;
              end
            end else begin
              state <= S_CMP;
            end
          end else begin
            tc    <= tc - CW'(1);
            state <= S_TR;
          end
        end
        S_CMP: begin
          state <= S_CMPW;
        end
        S_CMPW: begin
          if (cand_rd != best_rd || tc + CW'(1) == cols) begin
            if (cand_rd < best_rd) begin
              best_sel <= ~best_sel;
            end
            tc <= '0;
            if (idx_next == rows) begin
              state <= S_OUT_RD;
            end else begin
              idx   <= idx_next;
              state <= S_SCAN;
            end
          end else begin
            tc    <= tc + CW'(1);
            state <= S_CMP;
          end
        end
        S_OUT_RD: begin
          state <= S_OUT_CAP;
        end
        S_OUT_CAP: begin
          result_strobe <= 1'b1;
          path_row      <= 7'((RW)'(best_rd) + RW'(1));
          total_cost    <= total;
          last_item     <= (tc + CW'(1) == cols);
          if (tc + CW'(1) == cols) begin
            r     <= '0;
            col   <= '0;
            state <= S_IDLE;
          end else begin
            tc    <= tc + CW'(1);
            state <= S_OUT_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_wr) begin
        if (paddr[2] == mccp_pkg::REG_COLUMN_COUNT) begin
          column_count <= pwdata[6:0];
        end else begin
          row_count <= pwdata[6:0];
        end
        r   <= '0;
        col <= '0;
      end
    end
  end

  `ASSERT_CLK(a_strobe_from_output, result_strobe |-> $past(state == S_OUT_CAP))
  `ASSERT_CLK(a_row_in_range, (state == S_IDLE) |-> (r < rows))
  `ASSERT_CLK(a_start_goes_busy, (start && !busy && !cfg_wr) |=> busy)
  `ASSERT_NEVER(a_last_without_strobe, last_item && !result_strobe)

endmodule

>>> tb/sv/mccp_checker.sv
// Checker for the minimum-cost column path block: predicts path results and compares them.
module mccp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] cell_cost,
  input  logic        result_strobe,
  input  logic [6:0]  path_row,
  input  logic [21:0] total_cost,
  input  logic        last_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          result_total
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NR = 64;
  localparam int NC = 64;
  localparam int SW = mccp_pkg::SumWidth;

  typedef struct {
    logic [6:0]    row;
    logic [SW-1:0] total;
    logic          last;
  } path_entry_t;

  path_entry_t path_q[$];

  logic [6:0]       row_reg, col_reg;
  logic [SW-1:0]    acc_prev[NR];
  logic [SW-1:0]    acc_cur[NR];
  mccp_pkg::step_t  pred[NR*NC];
  int               cand[NC];
  int               best[NC];
  bit               best_ok;
  int               row_pos, col_pos;

  assign pending = path_q.size();

  function automatic int clamp_count(logic [6:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic void restart_grid();
    for (int i = 0; i < NR; i++) begin
      acc_prev[i] = '0;
      acc_cur[i] = '0;
    end
    row_pos = 0;
    col_pos = 0;
    best_ok = 0;
  endfunction

  function automatic void trace_row(int row, int rows, int cols);
    int              x;
    mccp_pkg::step_t s;
    x = row;
    for (int c = cols - 1; c >= 0; c--) begin
      cand[c] = x;
      s = pred[c*NR + x];
      if (s == mccp_pkg::STEP_UP && x > 0) x--;
      else if (s == mccp_pkg::STEP_DOWN && x + 1 < rows) x++;
    end
  endfunction

  function automatic void keep_smaller(int cols);
    if (!best_ok) begin
      best = cand;
      best_ok = 1;
      return;
    end
    for (int c = 0; c < cols; c++) begin
      if (cand[c] != best[c]) begin
        if (cand[c] < best[c]) best = cand;
        return;
      end
    end
  endfunction

  function automatic void add_cell(logic [15:0] cost);
    int              rows, cols, r;
    logic [SW-1:0]   m, total;
    logic [SW:0]     sum;
    mccp_pkg::step_t s;
    path_entry_t     e;
    rows = clamp_count(row_reg, NR);
    cols = clamp_count(col_reg, NC);
    if (row_pos >= rows || col_pos >= cols) restart_grid();
    r = row_pos;
    m = acc_prev[r];
    s = mccp_pkg::STEP_SAME;
    if (r > 0 && acc_prev[r-1] <= m) begin
      m = acc_prev[r-1];
      s = mccp_pkg::STEP_UP;
    end
    if (r + 1 < rows && acc_prev[r+1] < m) begin
      m = acc_prev[r+1];
      s = mccp_pkg::STEP_DOWN;
    end
    sum = {1'b0, m} + (SW+1)'(cost);
    acc_cur[r] = (sum > (SW+1)'(mccp_pkg::SumMax)) ? mccp_pkg::SumMax : sum[SW-1:0];
    pred[col_pos*NR + r] = s;
    row_pos = r + 1;
    if (row_pos < rows) return;
    row_pos = 0;
    acc_prev = acc_cur;
    col_pos++;
    if (col_pos < cols) return;
    total = acc_prev[0];
    for (int i = 1; i < rows; i++)
      if (acc_prev[i] < total) total = acc_prev[i];
    best_ok = 0;
    for (int i = 0; i < rows; i++) begin
      if (acc_prev[i] == total) begin
        trace_row(i, rows, cols);
        keep_smaller(cols);
      end
    end
    for (int c = 0; c < cols; c++) begin
      e.row = 7'(best[c] + 1);
      e.total = total;
      e.last = (c + 1 == cols);
      path_q.push_back(e);
    end
    restart_grid();
  endfunction

  always @(posedge clk) begin
    path_entry_t e;
    if (rst) begin
      row_reg <= 7'd1;
      col_reg <= 7'd1;
      for (int i = 0; i < NR*NC; i++) pred[i] = mccp_pkg::STEP_UP;
      for (int i = 0; i < NC; i++) begin
        cand[i] = 0;
        best[i] = 0;
      end
      restart_grid();
      path_q.delete();
      fail_count <= 0;
      result_total <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == mccp_pkg::REG_COLUMN_COUNT) col_reg <= pwdata[6:0];
        else row_reg <= pwdata[6:0];
        restart_grid();
      end else if (start && !busy) begin
        add_cell(cell_cost);
      end
      if (result_strobe) begin
        result_total <= result_total + 1;
        if (path_q.size() == 0) begin
          $error("unexpected result: path_row %0d total_cost %0d", path_row, total_cost);
          fail_count <= fail_count + 1;
        end else begin
          e = path_q.pop_front();
          if (path_row !== e.row || total_cost !== e.total || last_item !== e.last)
            fail_count <= fail_count + 1;
          if (path_row !== e.row)
            $error("path_row: expected %0d, actual %0d", e.row, path_row);
          if (total_cost !== e.total)
            $error("total_cost: expected %0d, actual %0d", e.total, total_cost);
          if (last_item !== e.last)
            $error("last_item: expected %0d, actual %0d", e.last, last_item);
        end
      end
    end
  end
endmodule

>>> tb/sv/tb_top.sv
// Top-level testbench for min_cost_column_path_top: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk, rst, start, busy, result_strobe, last_item;
  logic [15:0] cell_cost;
  logic [6:0]  path_row;
  logic [21:0] total_cost;
  logic        psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending, result_total;
  int          cells_sent, grids_done;
  bit          gaps_on;

  min_cost_column_path_top DUT (.*);

  mccp_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("** min_cost_column_path_top: FAILED **");
    $finish;
  end

  task automatic settle();
    do @(posedge clk); while (pending != 0 || busy);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(logic reg_idx, logic [6:0] value);
    @(negedge clk);
    psel = 1;
    pwrite = 1;
    penable = 0;
    paddr = {reg_idx, 2'b00};
    pwdata = {$urandom()} & 32'hFFFF_FF80 | 32'(value);
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0;
    penable = 0;
    pwrite = 0;
  endtask

  task automatic send_cell(logic [15:0] cost);
    bit acc;
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start = 0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    start = 1;
    cell_cost = cost;
    do begin
      @(posedge clk);
      acc = !busy;
    end while (!acc);
    cells_sent++;
    @(negedge clk);
    start = 0;
  endtask

  function automatic logic [15:0] pick_cost();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hFFFF - 16'($urandom_range(0, 2));
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic int clamp_n(logic [6:0] v);
    return (v == 0) ? 1 : (v > 64) ? 64 : v;
  endfunction

  // kind 0: random costs, 1: all zero, 2: all max
  task automatic run_phase(logic [6:0] rows, logic [6:0] cols, int grids, int kind);
    int n;
    settle();
    @(negedge clk);
    start = 0;
    cfg_write(mccp_pkg::REG_ROW_COUNT, rows);
    cfg_write(mccp_pkg::REG_COLUMN_COUNT, cols);
    n = clamp_n(rows) * clamp_n(cols);
    for (int g = 0; g < grids; g++) begin
      for (int i = 0; i < n; i++)
        send_cell(kind == 1 ? 16'h0 : kind == 2 ? 16'hFFFF : pick_cost());
      grids_done++;
      if ($urandom_range(0, 3) == 0) begin
        @(negedge clk);
        start = 0;
        do @(posedge clk); while (pending != 0);
      end
    end
  endtask

  initial begin
    logic [6:0] r, c;
    int         ng;
    rst = 1;
    start = 0;
    cell_cost = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    cells_sent = 0;
    grids_done = 0;
    gaps_on = 1;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 0;

    run_phase(7'd1, 7'd1, 2, 0);
    run_phase(7'd0, 7'd0, 1, 2);
    run_phase(7'd3, 7'd3, 1, 1);
    run_phase(7'd1, 7'd4, 1, 2);
    run_phase(7'd4, 7'd2, 1, 0);
    // drop a partial grid with a register write
    send_cell(16'h1234);
    send_cell(16'h00FF);
    run_phase(7'd2, 7'd2, 1, 0);
    run_phase(7'd127, 7'd2, 1, 0);
    run_phase(7'd2, 7'd127, 1, 0);
    run_phase(7'd64, 7'd1, 1, 0);

    while (cells_sent < 460) begin
      if (cells_sent > 400) gaps_on = 0;
      ng = $urandom_range(1, 3);
      if ($urandom_range(0, 11) == 0) begin
        r = 7'($urandom_range(0, 127));
        c = 7'($urandom_range(1, 3));
        ng = 1;
        if ($urandom_range(0, 1)) begin
          r = c;
          c = 7'($urandom_range(0, 127));
        end
      end else begin
        r = 7'($urandom_range(0, 9));
        c = 7'($urandom_range(0, 9));
      end
      run_phase(r, c, ng, $urandom_range(0, 15) == 0 ? 1 : 0);
    end

    @(negedge clk);
    start = 0;
    settle();
    $display("Covered %0d cells over %0d grids, %0d path entries checked,", cells_sent,
             grids_done, result_total);
    $display("including clamped sizes, edge rows, ties and dropped partial grids.");
    if (fail_count == 0) begin
      $display("** min_cost_column_path_top: PASSED **");
    end else begin
      $display("** min_cost_column_path_top: FAILED **");
    end
    $finish;
  end
endmodule
